>>> rtl/ptq_pkg.sv
// Shared types, codes and sizing for the parcel tracking queue.
// No dependencies; taken in by the core, the queue RAM user and the checker.
`default_nettype none

package ptq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(QUEUE_DEPTH);

	// event codes
	localparam logic [2:0] REQ_ENTRY  = 3'd0;
	localparam logic [2:0] REQ_GATE   = 3'd1;
	localparam logic [2:0] REQ_DONE   = 3'd2;
	localparam logic [2:0] REQ_ARRIVE = 3'd3;
	localparam logic [2:0] REQ_SCAN   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_GATE_EMPTY = 3'd2;
	localparam logic [2:0] ST_DEFAULTED = 3'd3;
	localparam logic [2:0] ST_ARR_EMPTY = 3'd4;
	localparam logic [2:0] ST_MIS_SORT  = 3'd5;
	localparam logic [2:0] ST_MALFORMED = 3'd6;
	localparam logic [2:0] ST_UNKNOWN   = 3'd7;

	typedef struct packed {
		logic [15:0] id;
		logic [3:0]  dest;
		logic        known;
	} ptq_entry_t;

	localparam int ENTRY_W = $bits(ptq_entry_t);

	typedef struct packed {
		logic        conveyor_running;
		logic        sorter_cmd_valid;
		logic [3:0]  sorter_target;
		logic        scan_request_valid;
		logic [15:0] scan_request_id;
		logic [2:0]  status;
		logic [15:0] status_parcel_id;
		logic [3:0]  expected_chute;
	} ptq_result_t;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ptq_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/parcel_tracking_queue_core.sv
// Parcel tracking queue: FIFO of parcel entries with event sequencer.
// Depends on ptq_pkg and ptq_ram.
`default_nettype none

// One event is taken at a time. Entry, gate, sorter-done and arrival events
// pass through the read, check and finish states before the next event can
// be accepted, with the result registered at the output. A scan response
// walks the queue from the rear through the single read port of the entry
// RAM, comparing one stored id per cycle until it finds the id or reaches the
// front. A finished result waits in the output register, so a new event can
// be taken while the previous result is still stalled.
module parcel_tracking_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        evt_valid,
	output      logic        evt_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [1:0]  chute_index,
	input  wire logic        scan_ok,
	input  wire logic [15:0] scan_parcel_id,
	input  wire logic [3:0]  scan_destination,
	output      logic        res_valid,
	input  wire logic        res_stall,
	output      logic        conveyor_running,
	output      logic        sorter_cmd_valid,
	output      logic [3:0]  sorter_target,
	output      logic        scan_request_valid,
	output      logic [15:0] scan_request_id,
	output      logic [2:0]  status,
	output      logic [15:0] status_parcel_id,
	output      logic [3:0]  expected_chute
);

	import ptq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_CHK  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [2:0]       req_q;
	logic [1:0]       chute_q;
	logic             ok_q;
	logic [15:0]      sid_q;
	logic [3:0]       sdest_q;
	logic [PTR_W-1:0] cur_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      next_id_q;
	logic             belt_q;
	ptq_result_t      res_q;
	ptq_result_t      out_q;
	logic             out_valid_q;

	logic [PTR_W-1:0] slot_cur;
	logic [PTR_W-1:0] slot_nxt;
	logic [PTR_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_word;
	ptq_entry_t       rd_data;
	ptq_entry_t       wr_data;
	logic [PTR_W-1:0] wr_addr;
	logic             wr_en;
	logic             ram_we;
	logic             done_chk;
	logic             out_free;
	ptq_result_t      res_d;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	logic [15:0]      next_id_d;
	logic             belt_d;
	logic [3:0]       exp_dest;
	logic [CNT_W-1:0] count_less;

	// offset from the front of the queue to a RAM slot
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
			input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_WIDE) begin
			sum = sum - DEPTH_WIDE;
		end
		return sum[PTR_W-1:0];
	endfunction

	assign slot_cur = slot_of(head_q, cur_q);
	assign slot_nxt = slot_of(head_q, cur_q - 1'b1);
	// during the walk, fetch the next entry nearer the front while checking this one
	assign rd_addr  = (state_q == S_CHK) ? slot_nxt : slot_cur;
	assign rd_data  = ptq_entry_t'(rd_word);
	assign ram_we   = (state_q == S_CHK) && wr_en;
	assign out_free = !out_valid_q || !res_stall;
	assign count_less = count_q - 1'b1;

	ptq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_word)
	);

	always_comb begin
		res_d     = '0;
		done_chk  = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = tail_q;
		wr_data   = '0;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		next_id_d = next_id_q;
		belt_d    = belt_q;
		exp_dest  = rd_data.known ? rd_data.dest : 4'd0;
		unique case (req_q)
			REQ_ENTRY: begin
				if (count_q == FULL_CNT) begin
					res_d.status = ST_FULL;
				end else begin
					wr_en                    = 1'b1;
					wr_data.id               = next_id_q;
					tail_d                   = wrap_next(tail_q);
					count_d                  = count_q + 1'b1;
					res_d.scan_request_valid = 1'b1;
					res_d.scan_request_id    = next_id_q;
					res_d.status_parcel_id   = next_id_q;
					next_id_d                = next_id_q + 16'd1;
				end
			end
			REQ_GATE: begin
				if (count_q == '0) begin
					res_d.status = ST_GATE_EMPTY;
				end else begin
					belt_d                 = 1'b0;
					res_d.sorter_cmd_valid = 1'b1;
					res_d.status_parcel_id = rd_data.id;
					if (rd_data.known) begin
						res_d.sorter_target = rd_data.dest;
					end else begin
						res_d.status = ST_DEFAULTED;
					end
				end
			end
			REQ_DONE: begin
				belt_d = 1'b1;
			end
			REQ_ARRIVE: begin
				// chute three does not exist: drop the event
				if (chute_q != 2'd3) begin
					if (count_q == '0) begin
						res_d.status = ST_ARR_EMPTY;
					end else begin
						res_d.expected_chute   = exp_dest;
						res_d.status_parcel_id = rd_data.id;
						if (exp_dest != {2'b00, chute_q}) begin
							res_d.status = ST_MIS_SORT;
						end
						head_d  = wrap_next(head_q);
						count_d = count_less;
					end
				end
			end
			REQ_SCAN: begin
				res_d.status_parcel_id = sid_q;
				if (!ok_q) begin
					res_d.status = ST_MALFORMED;
				end else if (count_q == '0) begin
					res_d.status = ST_UNKNOWN;
				end else if (rd_data.id == sid_q) begin
					wr_en         = 1'b1;
					wr_addr       = slot_cur;
					wr_data.id    = rd_data.id;
					wr_data.dest  = sdest_q;
					wr_data.known = 1'b1;
				end else if (cur_q == '0) begin
					res_d.status = ST_UNKNOWN;
				end else begin
					done_chk = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res_d.conveyor_running = belt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			next_id_q <= 16'd1;
			belt_q    <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						// scans start at the rear, all others read the front
						if (req_type == REQ_SCAN && count_q != '0) begin
							cur_q <= count_less[PTR_W-1:0];
						end else begin
							cur_q <= '0;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (done_chk) begin
						head_q    <= head_d;
						tail_q    <= tail_d;
						count_q   <= count_d;
						next_id_q <= next_id_d;
						belt_q    <= belt_d;
						state_q   <= S_FIN;
					end else begin
						cur_q <= cur_q - 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && evt_valid) begin
			req_q   <= req_type;
			chute_q <= chute_index;
			ok_q    <= scan_ok;
			sid_q   <= scan_parcel_id;
			sdest_q <= scan_destination;
		end
		if (state_q == S_CHK && done_chk) begin
			res_q <= res_d;
		end
		if (state_q == S_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	assign evt_stall          = (state_q != S_IDLE);
	assign res_valid          = out_valid_q;
	assign conveyor_running   = out_q.conveyor_running;
	assign sorter_cmd_valid   = out_q.sorter_cmd_valid;
	assign sorter_target      = out_q.sorter_target;
	assign scan_request_valid = out_q.scan_request_valid;
	assign scan_request_id    = out_q.scan_request_id;
	assign status             = out_q.status;
	assign status_parcel_id   = out_q.status_parcel_id;
	assign expected_chute     = out_q.expected_chute;

endmodule

`default_nettype wire

>>> rtl/ptq_checker.sv
// Port-level checks for the parcel tracking queue core, bound to the top level.
// Depends on ptq_pkg and parcel_tracking_queue_core.
`default_nettype none

module ptq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        evt_valid,
	input wire logic        evt_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        conveyor_running,
	input wire logic        sorter_cmd_valid,
	input wire logic        scan_request_valid,
	input wire logic [15:0] scan_request_id,
	input wire logic [2:0]  status,
	input wire logic [15:0] status_parcel_id
);

	import ptq_pkg::*;

	// one event at a time: the input closes right after an item is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall |=> evt_stall)
		else $error("event accepted while the previous one is still in work");

	a_sorter_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sorter_cmd_valid |->
			!conveyor_running && (status == ST_OK || status == ST_DEFAULTED))
		else $error("sorter command with running belt or wrong status");

	a_scan_req: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && scan_request_valid |->
			status == ST_OK && scan_request_id == status_parcel_id)
		else $error("scan request does not match the reported parcel");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=>
			res_valid && $stable(status) && $stable(status_parcel_id))
		else $error("stalled result changed");

endmodule

bind parcel_tracking_queue_core ptq_checker u_ptq_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for parcel_tracking_queue_core: directed script, then random event traffic.
// Depends on rtl/ptq_pkg.sv and rtl/parcel_tracking_queue_core.sv.
`timescale 1ns / 100ps

module tb_top;
	import ptq_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam logic [1:0] CHUTE_NONE   = 2'd3;
	localparam logic [1:0] CHUTE_LAST   = 2'd2;

	localparam int RESET_CYCLES   = 9;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int LONG_HOLD      = 400;

	typedef struct packed {
		logic [2:0]  req;
		logic [1:0]  chute;
		logic        ok;
		logic [15:0] id;
		logic [3:0]  dest;
	} parcel_evt_t;

	typedef struct {
		parcel_evt_t evt;
		int          reps;
		bit          typed;
		ptq_result_t want;
	} script_row_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_stall;
	logic [2:0]  req_type = '0;
	logic [1:0]  chute_index = '0;
	logic        scan_ok = 1'b0;
	logic [15:0] scan_parcel_id = '0;
	logic [3:0]  scan_destination = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        conveyor_running;
	logic        sorter_cmd_valid;
	logic [3:0]  sorter_target;
	logic        scan_request_valid;
	logic [15:0] scan_request_id;
	logic [2:0]  status;
	logic [15:0] status_parcel_id;
	logic [3:0]  expected_chute;

	// tracker copy of the belt queue
	logic [15:0] slot_id    [QUEUE_DEPTH];
	logic [3:0]  slot_dest  [QUEUE_DEPTH];
	logic        slot_known [QUEUE_DEPTH];
	int unsigned front, rear, held;
	logic [15:0] next_id;
	logic        belt_running;

	ptq_result_t awaited[$];
	ptq_result_t seen_want;
	script_row_t script[$];
	int          fail_count = 0;
	int          cycles = 0;
	int          burst_left = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	int          rx_left = 0;
	int          rx_tick = 0;

	parcel_tracking_queue_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.evt_valid         (evt_valid),
		.evt_stall         (evt_stall),
		.req_type          (req_type),
		.chute_index       (chute_index),
		.scan_ok           (scan_ok),
		.scan_parcel_id    (scan_parcel_id),
		.scan_destination  (scan_destination),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.conveyor_running  (conveyor_running),
		.sorter_cmd_valid  (sorter_cmd_valid),
		.sorter_target     (sorter_target),
		.scan_request_valid(scan_request_valid),
		.scan_request_id   (scan_request_id),
		.status            (status),
		.status_parcel_id  (status_parcel_id),
		.expected_chute    (expected_chute)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ptq_result_t res(input logic run, input logic cmd, input logic [3:0] tgt,
			input logic reqv, input logic [15:0] reqid, input logic [2:0] st,
			input logic [15:0] stid, input logic [3:0] chute);
		ptq_result_t r;
		r.conveyor_running   = run;
		r.sorter_cmd_valid   = cmd;
		r.sorter_target      = tgt;
		r.scan_request_valid = reqv;
		r.scan_request_id    = reqid;
		r.status             = st;
		r.status_parcel_id   = stid;
		r.expected_chute     = chute;
		return r;
	endfunction

	function automatic logic [3:0] front_chute();
		return slot_known[front] ? slot_dest[front] : 4'd0;
	endfunction

	// advance the tracker by one event and return the result it should give
	function automatic ptq_result_t track_event(input parcel_evt_t e);
		ptq_result_t r;
		int          i;
		int unsigned s;
		bit          found;
		r = '0;
		case (e.req)
			REQ_ENTRY: begin
				if (held >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot_id[rear]    = next_id;
					slot_dest[rear]  = 4'd0;
					slot_known[rear] = 1'b0;
					rear = (rear + 1) % QUEUE_DEPTH;
					held++;
					r.scan_request_valid = 1'b1;
					r.scan_request_id    = next_id;
					r.status_parcel_id   = next_id;
					next_id = next_id + 16'd1;
				end
			end
			REQ_GATE: begin
				if (held == 0) begin
					r.status = ST_GATE_EMPTY;
				end else begin
					belt_running       = 1'b0;
					r.sorter_cmd_valid = 1'b1;
					r.status_parcel_id = slot_id[front];
					if (slot_known[front]) begin
						r.sorter_target = slot_dest[front];
					end else begin
						r.status = ST_DEFAULTED;
					end
				end
			end
			REQ_DONE: belt_running = 1'b1;
			REQ_ARRIVE: begin
				if (e.chute <= CHUTE_LAST) begin
					if (held == 0) begin
						r.status = ST_ARR_EMPTY;
					end else begin
						r.expected_chute   = front_chute();
						r.status_parcel_id = slot_id[front];
						if (r.expected_chute != {2'b00, e.chute})
							r.status = ST_MIS_SORT;
						front = (front + 1) % QUEUE_DEPTH;
						held--;
					end
				end
			end
			REQ_SCAN: begin
				r.status_parcel_id = e.id;
				if (!e.ok) begin
					r.status = ST_MALFORMED;
				end else begin
					found = 1'b0;
					// newest entry wins when an id appears twice
					for (i = int'(held) - 1; i >= 0 && !found; i--) begin
						s = (front + i) % QUEUE_DEPTH;
						if (slot_id[s] == e.id) begin
							slot_dest[s]  = e.dest;
							slot_known[s] = 1'b1;
							found = 1'b1;
						end
					end
					if (!found)
						r.status = ST_UNKNOWN;
				end
			end
			default: ;
		endcase
		r.conveyor_running = belt_running;
		return r;
	endfunction

	function automatic parcel_evt_t pick_event();
		parcel_evt_t e;
		int          r;
		int unsigned k;
		logic [3:0]  fc;
		e.req   = REQ_ENTRY;
		e.chute = 2'($urandom_range(0, 3));
		e.ok    = 1'($urandom_range(0, 1));
		e.id    = 16'($urandom_range(0, 65535));
		e.dest  = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 24) begin
			e.req = REQ_ENTRY;
		end else if (r < 50) begin
			e.req = REQ_SCAN;
			if ($urandom_range(0, 1))
				e.dest = 4'($urandom_range(0, 2));
			r = $urandom_range(0, 99);
			if (r < 70 && held > 0) begin
				k = $urandom_range(0, held - 1);
				e.ok = 1'b1;
				e.id = slot_id[(front + k) % QUEUE_DEPTH];
			end else if (r < 85) begin
				e.ok = 1'b1;
			end else begin
				e.ok = 1'b0;
			end
		end else if (r < 62) begin
			e.req = REQ_GATE;
		end else if (r < 72) begin
			e.req = REQ_DONE;
		end else if (r < 93) begin
			e.req = REQ_ARRIVE;
			// mostly send the parcel where it belongs
			if (held > 0 && $urandom_range(0, 3) != 0) begin
				fc = front_chute();
				e.chute = (fc <= 4'd2) ? fc[1:0] : 2'($urandom_range(0, 2));
			end
		end else begin
			e.req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return e;
	endfunction

	task automatic add_row(input logic [2:0] req, input logic [1:0] chute, input logic ok,
			input logic [15:0] id, input logic [3:0] dest, input int reps, input bit typed,
			input ptq_result_t want);
		script_row_t row;
		row.evt   = '{req: req, chute: chute, ok: ok, id: id, dest: dest};
		row.reps  = reps;
		row.typed = typed;
		row.want  = want;
		script.push_back(row);
	endtask

	// call at a rising edge; returns at the edge where the item was taken
	task automatic offer(input parcel_evt_t e, input bit typed, input ptq_result_t want);
		ptq_result_t predicted;
		req_type         <= e.req;
		chute_index      <= e.chute;
		scan_ok          <= e.ok;
		scan_parcel_id   <= e.id;
		scan_destination <= e.dest;
		evt_valid        <= 1'b1;
		@(posedge clk);
		while (evt_stall !== 1'b0)
			@(posedge clk);
		predicted = track_event(e);
		awaited.push_back(typed ? want : predicted);
	endtask

	task automatic feed_random(input int n);
		parcel_evt_t e;
		int          counted;
		int          gap;
		counted = 0;
		while (counted < n) begin
			e = pick_event();
			if (e.req <= REQ_SCAN && !(e.req == REQ_ARRIVE && e.chute == CHUTE_NONE))
				counted++;
			offer(e, 1'b0, '0);
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 15);
				evt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 50);
			end
		end
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		while (awaited.size() > 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (awaited.size() == 0) begin
				$error("result item with nothing outstanding");
				fail_count++;
			end else begin
				seen_want = awaited.pop_front();
				check_field("conveyor_running", 16'(seen_want.conveyor_running),
					16'(conveyor_running));
				check_field("sorter_cmd_valid", 16'(seen_want.sorter_cmd_valid),
					16'(sorter_cmd_valid));
				check_field("sorter_target", 16'(seen_want.sorter_target),
					16'(sorter_target));
				check_field("scan_request_valid", 16'(seen_want.scan_request_valid),
					16'(scan_request_valid));
				check_field("scan_request_id", seen_want.scan_request_id, scan_request_id);
				check_field("status", 16'(seen_want.status), 16'(status));
				check_field("status_parcel_id", seen_want.status_parcel_id, status_parcel_id);
				check_field("expected_chute", 16'(seen_want.expected_chute),
					16'(expected_chute));
			end
		end
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_FREE:  res_stall <= 1'b0;
				RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default:  res_stall <= ((rx_tick % 5) < 2);
			endcase
		end
	end

	initial begin : main
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slot_id[i]    = '0;
			slot_dest[i]  = '0;
			slot_known[i] = 1'b0;
		end
		front        = 0;
		rear         = 0;
		held         = 0;
		next_id      = 16'd1;
		belt_running = 1'b1;

		// empty queue, ignored events and bad scans first
		add_row(REQ_GATE, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_GATE_EMPTY, 16'd0, 4'd0));
		add_row(REQ_ARRIVE, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_ARR_EMPTY, 16'd0, 4'd0));
		add_row(REQ_ARRIVE, CHUTE_NONE, 1'b1, 16'hFFFF, 4'd15, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_OK, 16'd0, 4'd0));
		add_row(REQ_SPARE_LO, CHUTE_NONE, 1'b1, 16'hFFFF, 4'd15, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_OK, 16'd0, 4'd0));
		add_row(REQ_SPARE_HI, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_OK, 16'd0, 4'd0));
		add_row(REQ_SCAN, 2'd0, 1'b0, 16'hFFFF, 4'd15, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_MALFORMED, 16'hFFFF, 4'd0));
		add_row(REQ_SCAN, 2'd0, 1'b1, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_UNKNOWN, 16'h0000, 4'd0));
		// first parcel, gated before its scan comes back
		add_row(REQ_ENTRY, CHUTE_NONE, 1'b1, 16'hFFFF, 4'd15, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b1, 16'd1, ST_OK, 16'd1, 4'd0));
		add_row(REQ_GATE, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b0, 1'b1, 4'd0, 1'b0, 16'd0, ST_DEFAULTED, 16'd1, 4'd0));
		add_row(REQ_DONE, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b1,
			res(1'b1, 1'b0, 4'd0, 1'b0, 16'd0, ST_OK, 16'd0, 4'd0));
		add_row(REQ_SCAN, 2'd0, 1'b1, 16'd1, 4'd15, 1, 1'b0, '0);
		add_row(REQ_GATE, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b0, '0);
		add_row(REQ_ARRIVE, CHUTE_LAST, 1'b0, 16'h0000, 4'd0, 1, 1'b0, '0);
		// fill to the brim, then one more
		add_row(REQ_ENTRY, 2'd0, 1'b0, 16'h0000, 4'd0, QUEUE_DEPTH, 1'b0, '0);
		add_row(REQ_ENTRY, 2'd0, 1'b0, 16'h0000, 4'd0, 1, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			repeat (script[i].reps)
				offer(script[i].evt, script[i].typed, script[i].want);

		feed_random(200);
		hold_req = 1'b1;
		feed_random(200);
		drain();
		feed_random(150);
		drain();

		feed_random(550);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && awaited.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
